// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk_i and disabled while rst_ni is low.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same check, but on the cycle after the triggering condition.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/kbtq_pkg.sv -----
`default_nettype none

package kbtq_pkg;

  localparam int QueueDepth = 80;
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int KeyW       = 16;
  localparam int OutCountW  = 7;

  typedef enum logic [1:0] {
    ReqAdd   = 2'd0,
    ReqPeek  = 2'd1,
    ReqPop   = 2'd2,
    ReqClear = 2'd3
  } req_e;

  // Modifier bit positions.
  localparam int ShiftBit = 0;
  localparam int CtrlBit  = 1;

  localparam logic [KeyW-1:0] ModMask     = 16'hFE00;
  localparam logic [KeyW-1:0] KeyShiftOn  = 16'hFF10;
  localparam logic [KeyW-1:0] KeyShiftOff = 16'hFE10;
  localparam logic [KeyW-1:0] KeyCtrlOn   = 16'hFF11;
  localparam logic [KeyW-1:0] KeyCtrlOff  = 16'hFE11;
  localparam logic [KeyW-1:0] KeyEscape   = 16'd27;

  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/kbtq_cell.sv -----
`default_nettype none

module kbtq_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire kbtq_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic                        prev_valid_i,
  input  wire logic                        next_valid_i,
  input  wire logic [kbtq_pkg::KeyW-1:0]   next_data_i,
  input  wire logic [kbtq_pkg::KeyW-1:0]   push_data_i,
  output logic                             valid_o,
  output logic [kbtq_pkg::KeyW-1:0]        data_o
);

  logic                      valid_q, valid_d;
  logic [kbtq_pkg::KeyW-1:0] data_q, data_d;

  // A pop shifts every entry one cell toward the head. A push lands in the
  // first empty cell, which is the one whose lower neighbor is occupied.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    priority if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end else if (ctrl_i.push && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/kbtq_remap.sv -----
`default_nettype none

module kbtq_remap (
  input  wire logic [kbtq_pkg::KeyW-1:0] key_i,
  input  wire logic [1:0]                mod_i,
  output logic [kbtq_pkg::KeyW-1:0]      key_o
);

  localparam logic [7:0] AsciiTab   = 8'd9;
  localparam logic [7:0] ScanBackTab = 8'd15;
  localparam logic [7:0] ScanF1     = 8'd59;
  localparam logic [7:0] ScanF10    = 8'd68;
  localparam logic [7:0] ShiftFnOfs = 8'd25;
  localparam logic [7:0] CtrlFnOfs  = 8'd35;
  localparam logic [7:0] ScanHome   = 8'd71;
  localparam logic [7:0] ScanPgUp   = 8'd73;
  localparam logic [7:0] ScanLeft   = 8'd75;
  localparam logic [7:0] ScanRight  = 8'd77;
  localparam logic [7:0] ScanEnd    = 8'd79;
  localparam logic [7:0] ScanPgDn   = 8'd81;
  localparam logic [7:0] CtrlHome   = 8'd119;
  localparam logic [7:0] CtrlPgUp   = 8'd132;
  localparam logic [7:0] CtrlLeft   = 8'd115;
  localparam logic [7:0] CtrlRight  = 8'd116;
  localparam logic [7:0] CtrlEnd    = 8'd117;
  localparam logic [7:0] CtrlPgDn   = 8'd118;

  logic [7:0] scan;
  logic [7:0] ascii;
  logic       is_fn;

  assign scan  = key_i[15:8];
  assign ascii = key_i[7:0];
  assign is_fn = (ascii == 8'd0) && (scan >= ScanF1) && (scan <= ScanF10);

  always_comb begin
    key_o = key_i;
    if (mod_i[kbtq_pkg::ShiftBit]) begin
      // Tab turns into back-tab, which is not a function key, so the two
      // shift rules never both apply.
      if (ascii == AsciiTab) begin
        key_o = {ScanBackTab, 8'd0};
      end else if (is_fn) begin
        key_o = {8'(scan + ShiftFnOfs), 8'd0};
      end
    end else if (mod_i[kbtq_pkg::CtrlBit] && ascii == 8'd0) begin
      if (is_fn) begin
        key_o = {8'(scan + CtrlFnOfs), 8'd0};
      end else if (scan == ScanHome) begin
        key_o = {CtrlHome, 8'd0};
      end else if (scan == ScanPgUp) begin
        key_o = {CtrlPgUp, 8'd0};
      end else if (scan == ScanLeft) begin
        key_o = {CtrlLeft, 8'd0};
      end else if (scan == ScanRight) begin
        key_o = {CtrlRight, 8'd0};
      end else if (scan == ScanEnd) begin
        key_o = {CtrlEnd, 8'd0};
      end else if (scan == ScanPgDn) begin
        key_o = {CtrlPgDn, 8'd0};
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/keyboard_typeahead_queue.sv -----
// Keyboard typeahead queue with shift and ctrl tracking.
// Requests arrive on the s_axis channel: tuser carries the request kind
// (add, peek, pop, clear) and tdata the 16-bit key code. Every request
// produces exactly one result on m_axis: tdata[15:0] is the key value and
// tdata[22:16] the number of keys held after the request.
// The queue is a row of cells; a pop shifts all entries one cell toward the
// head and a push fills the first empty cell, so the oldest key always sits
// in cell zero. Each request is resolved in the cycle it is accepted and its
// result is registered; one request per cycle is sustained while the result
// side keeps tready high.
// When m_axis stalls, the result register holds and s_axis_tready drops until
// the pending result is taken; a new request is accepted in the same cycle
// the old result leaves.
// The text_active register is written over the cfg channel, which is always
// ready. Reset empties the queue, clears both modifiers and text_active; no
// clearing pass is needed after reset.
`default_nettype none

module keyboard_typeahead_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] key_code
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] key_value, [22:16] queue_count
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);

  localparam int Depth = kbtq_pkg::QueueDepth;
  localparam int CW    = kbtq_pkg::CountW;
  localparam int KW    = kbtq_pkg::KeyW;

  logic                 active_q;
  logic [CW-1:0]        count_q, count_d;
  logic [1:0]           mod_q, mod_d;
  logic                 out_valid_q, out_valid_d;
  logic [23:0]          out_data_q, out_data_d;

  kbtq_pkg::cell_ctrl_t ctrl;
  kbtq_pkg::req_e       req;
  logic                 accept;
  logic                 full;
  logic [KW-1:0]        key_in;
  logic [KW-1:0]        key_mapped;
  logic [KW-1:0]        result;

  logic [Depth-1:0]     cell_valid;
  logic [KW-1:0]        cell_data [Depth];

  assign req           = kbtq_pkg::req_e'(s_axis_tuser);
  assign key_in        = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CW'(Depth));
  assign cfg_ready_o   = 1'b1;

  kbtq_remap u_remap (
    .key_i (key_in),
    .mod_i (mod_q),
    .key_o (key_mapped)
  );

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic          prev_valid;
    logic          next_valid;
    logic [KW-1:0] next_data;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_data  = '0;
    end else begin : g_link
      assign next_valid = cell_valid[i+1];
      assign next_data  = cell_data[i+1];
    end

    kbtq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_data_i  (next_data),
      .push_data_i  (key_mapped),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i])
    );
  end

  always_comb begin
    ctrl    = '0;
    count_d = count_q;
    mod_d   = mod_q;
    result  = '0;
    if (accept) begin
      unique case (req)
        kbtq_pkg::ReqAdd: begin
          if (active_q && !full) begin
            if ((key_in & kbtq_pkg::ModMask) == kbtq_pkg::ModMask) begin
              // Modifier events only touch the modifier bits; unknown ones vanish.
              if (key_in == kbtq_pkg::KeyShiftOn) begin
                mod_d[kbtq_pkg::ShiftBit] = 1'b1;
              end else if (key_in == kbtq_pkg::KeyShiftOff) begin
                mod_d[kbtq_pkg::ShiftBit] = 1'b0;
              end else if (key_in == kbtq_pkg::KeyCtrlOn) begin
                mod_d[kbtq_pkg::CtrlBit] = 1'b1;
              end else if (key_in == kbtq_pkg::KeyCtrlOff) begin
                mod_d[kbtq_pkg::CtrlBit] = 1'b0;
              end
            end else begin
              ctrl.push = 1'b1;
              count_d   = count_q + CW'(1);
            end
          end
        end
        kbtq_pkg::ReqPeek, kbtq_pkg::ReqPop: begin
          if (!active_q) begin
            result = kbtq_pkg::KeyEscape;
          end else if (count_q != '0) begin
            result = cell_data[0];
            if (req == kbtq_pkg::ReqPop) begin
              ctrl.pop = 1'b1;
              count_d  = count_q - CW'(1);
            end
          end
        end
        kbtq_pkg::ReqClear: begin
          ctrl.clear = 1'b1;
          count_d    = '0;
          mod_d      = '0;
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, kbtq_pkg::OutCountW'(count_d), result};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      count_q     <= '0;
      mod_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
      count_q     <= count_d;
      mod_q       <= mod_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/kbtq_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module kbtq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o
);

  logic in_xfer;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // A stalled result must stay put.
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Every accepted request shows a result in the next cycle.
  `ASSERT_NEXT(a_result_follows, in_xfer, m_axis_tvalid,
    "accepted request produced no result")

  // A clear answers zero and leaves the queue empty.
  `ASSERT_NEXT(a_clear_empties, in_xfer && s_axis_tuser == kbtq_pkg::ReqClear,
    m_axis_tdata[22:0] == 23'd0, "clear did not empty the queue")

  // An add never returns a key.
  `ASSERT_NEXT(a_add_zero, in_xfer && s_axis_tuser == kbtq_pkg::ReqAdd,
    m_axis_tdata[15:0] == 16'd0, "add returned a nonzero key")

  // The configuration channel never pushes back.
  `ASSERT_CLKD(a_cfg_ready, !cfg_valid_i || cfg_ready_o, "configuration write stalled")

endmodule

bind keyboard_typeahead_queue kbtq_checker u_kbtq_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;
  import kbtq_pkg::*;

  localparam int TargetItems  = 1700;
  localparam int SettleCycles = 3;

  // Scan codes that the modifier remapping looks at.
  localparam logic [7:0] AsciiTab    = 8'd9;
  localparam logic [7:0] ScanBackTab = 8'd15;
  localparam logic [7:0] ScanF1      = 8'd59;
  localparam logic [7:0] ScanF10     = 8'd68;
  localparam logic [7:0] ScanHome    = 8'd71;
  localparam logic [7:0] ScanPgUp    = 8'd73;
  localparam logic [7:0] ScanLeft    = 8'd75;
  localparam logic [7:0] ScanRight   = 8'd77;
  localparam logic [7:0] ScanEnd     = 8'd79;
  localparam logic [7:0] ScanPgDn    = 8'd81;

  typedef enum logic [1:0] {
    StepRequest,
    StepConfig,
    StepDrain
  } step_kind_e;

  typedef struct {
    step_kind_e      kind;
    req_e            req;
    logic [KeyW-1:0] code;
    logic            open;
  } keystroke_t;

  typedef struct {
    logic [KeyW-1:0]      value;
    logic [OutCountW-1:0] count;
  } key_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  keyboard_typeahead_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // Predicted queue state.
  logic [KeyW-1:0] key_mem [QueueDepth];
  int              head_idx = 0;
  int              tail_idx = 0;
  int              key_total = 0;
  logic [1:0]      mod_state = '0;
  logic            window_open = 1'b0;

  keystroke_t keystroke_q [$];
  key_reply_t pending_replies [$];

  int sent_cnt = 0;
  int accepted_cnt = 0;
  int results_cnt = 0;
  int cfg_sent = 0;
  int cfg_done = 0;
  int err_cnt = 0;
  int full_drops = 0;
  int active_items = 0;
  logic plan_open = 1'b0;

  function automatic logic [KeyW-1:0] apply_modifiers(logic [KeyW-1:0] raw);
    logic [KeyW-1:0] k;
    logic [7:0]      sc;
    k  = raw;
    sc = raw[15:8];
    if (mod_state[ShiftBit]) begin
      if (k[7:0] == AsciiTab) begin
        k  = {ScanBackTab, 8'h00};
        sc = ScanBackTab;
      end
      if (k[7:0] == 8'h00 && sc >= ScanF1 && sc <= ScanF10) k = {sc + 8'd25, 8'h00};
    end else if (mod_state[CtrlBit] && k[7:0] == 8'h00) begin
      if (sc >= ScanF1 && sc <= ScanF10) begin
        k = {sc + 8'd35, 8'h00};
      end else begin
        case (sc)
          ScanHome:  k = {8'd119, 8'h00};
          ScanPgUp:  k = {8'd132, 8'h00};
          ScanLeft:  k = {8'd115, 8'h00};
          ScanRight: k = {8'd116, 8'h00};
          ScanEnd:   k = {8'd117, 8'h00};
          ScanPgDn:  k = {8'd118, 8'h00};
          default: ;
        endcase
      end
    end
    return k;
  endfunction

  function automatic key_reply_t serve_request(req_e req, logic [KeyW-1:0] code);
    key_reply_t r;
    r.value = '0;
    case (req)
      ReqAdd: begin
        if (window_open && key_total >= QueueDepth) full_drops++;
        if (window_open && key_total < QueueDepth) begin
          if ((code & ModMask) == ModMask) begin
            if (code == KeyShiftOn)  mod_state[ShiftBit] = 1'b1;
            if (code == KeyShiftOff) mod_state[ShiftBit] = 1'b0;
            if (code == KeyCtrlOn)   mod_state[CtrlBit]  = 1'b1;
            if (code == KeyCtrlOff)  mod_state[CtrlBit]  = 1'b0;
          end else begin
            key_mem[tail_idx] = apply_modifiers(code);
            tail_idx = (tail_idx + 1) % QueueDepth;
            key_total++;
          end
        end
      end
      ReqClear: begin
        head_idx  = 0;
        tail_idx  = 0;
        key_total = 0;
        mod_state = '0;
      end
      default: begin
        if (!window_open) begin
          r.value = KeyEscape;
        end else if (key_total != 0) begin
          r.value = key_mem[head_idx];
          if (req == ReqPop) begin
            head_idx = (head_idx + 1) % QueueDepth;
            key_total--;
          end
        end
      end
    endcase
    r.count = OutCountW'(key_total);
    return r;
  endfunction

  // Monitor: predicts on accepted requests and register writes, checks results.
  always @(posedge clk_i) begin
    key_reply_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        window_open = cfg_data_i;
        cfg_done++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_replies.push_back(serve_request(req_e'(s_axis_tuser), s_axis_tdata));
        accepted_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_cnt++;
        if (pending_replies.size() == 0) begin
          $error("result transfer with no request outstanding: tdata=%h", m_axis_tdata);
          err_cnt++;
        end else begin
          want = pending_replies.pop_front();
          if (m_axis_tdata[15:0] !== want.value) begin
            $error("key_value: expected %h, got %h", want.value, m_axis_tdata[15:0]);
            err_cnt++;
          end
          if (m_axis_tdata[22:16] !== want.count) begin
            $error("queue_count: expected %0d, got %0d", want.count, m_axis_tdata[22:16]);
            err_cnt++;
          end
        end
      end
    end
  end

  // Driver for the request and register channels.
  int   gap_left = 0;
  int   settle_cnt = 0;
  logic tx_calm = 1'b0;

  always @(negedge clk_i) begin
    logic       nv;
    logic       ncv;
    keystroke_t head;
    if (rst_ni) begin
      nv  = s_axis_tvalid;
      ncv = cfg_valid_i;
      if (nv && accepted_cnt == sent_cnt) nv = 1'b0;
      if (ncv && cfg_done == cfg_sent) ncv = 1'b0;
      if (!nv && accepted_cnt == sent_cnt && pending_replies.size() == 0) settle_cnt++;
      else settle_cnt = 0;
      if (!nv && !ncv && keystroke_q.size() > 0) begin
        head = keystroke_q[0];
        case (head.kind)
          StepRequest: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              nv = 1'b1;
              s_axis_tuser <= head.req;
              s_axis_tdata <= head.code;
              sent_cnt++;
              void'(keystroke_q.pop_front());
              if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
              gap_left = tx_calm ? 0 : $urandom_range(0, 14);
            end
          end
          StepConfig: begin
            if (settle_cnt >= SettleCycles) begin
              ncv = 1'b1;
              cfg_data_i <= head.open;
              cfg_sent++;
              void'(keystroke_q.pop_front());
            end
          end
          default: begin
            if (settle_cnt >= 1) void'(keystroke_q.pop_front());
          end
        endcase
      end
      s_axis_tvalid <= nv;
      cfg_valid_i   <= ncv;
    end
  end

  // Result sink with random back-pressure after each transfer.
  int   rx_seen = 0;
  int   stall_left = 0;
  logic rx_calm = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (results_cnt != rx_seen) begin
        rx_seen = results_cnt;
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 14);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_step(req_e req, logic [KeyW-1:0] code);
    keystroke_t s;
    s.kind = StepRequest;
    s.req  = req;
    s.code = code;
    s.open = 1'b0;
    keystroke_q.push_back(s);
    if (plan_open) active_items++;
  endtask

  task automatic add_cfg(logic open);
    keystroke_t s;
    s.kind = StepConfig;
    s.req  = ReqAdd;
    s.code = '0;
    s.open = open;
    keystroke_q.push_back(s);
    plan_open = open;
  endtask

  task automatic add_drain();
    keystroke_t s;
    s.kind = StepDrain;
    s.req  = ReqAdd;
    s.code = '0;
    s.open = 1'b0;
    keystroke_q.push_back(s);
  endtask

  function automatic logic [KeyW-1:0] pick_key_code();
    logic [7:0] nav [6];
    nav = '{ScanHome, ScanPgUp, ScanLeft, ScanRight, ScanEnd, ScanPgDn};
    case ($urandom_range(0, 9))
      0, 1: return KeyW'($urandom);
      2:    return {8'(ScanF1 + $urandom_range(0, 9)), 8'h00};
      3:    return {nav[$urandom_range(0, 5)], 8'h00};
      4:    return {8'($urandom), AsciiTab};
      5: begin
        case ($urandom_range(0, 3))
          0: return KeyShiftOn;
          1: return KeyShiftOff;
          2: return KeyCtrlOn;
          default: return KeyCtrlOff;
        endcase
      end
      6:    return {7'h7F, 9'($urandom)};
      7:    return {8'($urandom), 8'h00};
      default: return {8'($urandom), 8'($urandom_range(32, 126))};
    endcase
  endfunction

  function automatic req_e pick_request(int add_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_pct) return ReqAdd;
    if (r < add_pct + 2) return ReqClear;
    return (r % 2 == 0) ? ReqPeek : ReqPop;
  endfunction

  initial begin
    int phase_len;
    int add_pct;
    int phase_cnt;

    // Window closed after reset: adds are dropped, reads answer escape, clear still works.
    add_step(ReqAdd, 16'h1E61);
    add_step(ReqPeek, 16'h0000);
    add_step(ReqPop, 16'hFFFF);
    add_step(ReqClear, 16'h0000);
    add_cfg(1'b1);
    add_step(ReqPeek, 16'h0000);
    add_step(ReqPop, 16'h0000);
    add_step(ReqAdd, 16'hFFFF);            // modifier pattern that matches no modifier
    add_step(ReqAdd, 16'h0000);
    add_step(ReqAdd, 16'h0F09);
    add_step(ReqAdd, KeyShiftOn);
    add_step(ReqAdd, 16'h0F09);
    add_step(ReqAdd, 16'h4400);
    add_step(ReqAdd, KeyCtrlOn);
    add_step(ReqAdd, 16'h3B00);            // shift and ctrl held: shift wins
    add_step(ReqAdd, KeyShiftOff);
    add_step(ReqAdd, 16'h3B00);
    add_step(ReqAdd, 16'h4700);
    add_step(ReqAdd, 16'h5100);
    add_step(ReqAdd, KeyCtrlOff);
    add_step(ReqAdd, 16'h4400);
    add_step(ReqPop, 16'h0000);
    add_step(ReqPop, 16'h0000);
    add_step(ReqPeek, 16'h0000);
    add_step(ReqClear, 16'h0000);
    add_step(ReqPop, 16'h0000);

    phase_cnt = 0;
    while (active_items < TargetItems) begin
      phase_cnt++;
      if (phase_cnt == 2 || $urandom_range(0, 7) == 0) add_drain();
      if ($urandom_range(0, 5) == 0) begin
        // Closed-window stretch, with whatever the queue holds behind it.
        add_cfg(1'b0);
        repeat ($urandom_range(10, 30)) add_step(pick_request(40), pick_key_code());
        add_cfg(1'b1);
      end
      case ($urandom_range(0, 2))
        0: begin
          add_pct   = 80;
          phase_len = $urandom_range(120, 220);
        end
        1: begin
          add_pct   = 25;
          phase_len = $urandom_range(40, 150);
        end
        default: begin
          add_pct   = 50;
          phase_len = $urandom_range(40, 200);
        end
      endcase
      repeat (phase_len) add_step(pick_request(add_pct), pick_key_code());
    end

    while (keystroke_q.size() != 0 || accepted_cnt != sent_cnt || pending_replies.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d results from %0d requests, %0d text_active writes.",
             results_cnt, sent_cnt, cfg_done);
    $display("Adds refused by a full queue: %0d; mismatches: %0d.", full_drops, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
